[sv/skrn_pkg.sv]
// ----------------------------------------------------------------------------
// skrn_pkg: shared types and constants for the sorted key ring
// Sizes of the entry table, transaction payload structs, action and status
// codes.
// ----------------------------------------------------------------------------
package skrn_pkg;

	// Table sizing
	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Payload field widths
	localparam int ACT_W   = 3;
	localparam int KEY_W   = 16;
	localparam int HDL_W   = 16;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 7;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_NEIGH  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SET    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_GET    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_KEYOF  = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

	// Handle value meaning "none"
	localparam logic [HDL_W-1:0] NO_HANDLE = 16'hFFFF;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic [KEY_W-1:0]        key;
		logic signed [HDL_W-1:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic [KEY_W-1:0]        left_key;
		logic [KEY_W-1:0]        right_key;
		logic [KEY_W-1:0]        found_key;
		logic signed [HDL_W-1:0] found_handle;
		logic [TOTAL_W-1:0]      entry_total;
	} res_t;

endpackage

[sv/sorted_key_ring_neighbors.sv]
// ----------------------------------------------------------------------------
// sorted_key_ring_neighbors: bounded ascending ring of keys with handles
// Usage: a command transaction (cmd, cmd_valid/cmd_stall) carries an action,
// a key and a handle; each command yields exactly one result transaction
// (res, res_valid/res_stall) with a status, neighbor keys, lookup fields and
// the entry count after the action. Entries live in two single-port-read
// tables (keys, handles) swept one entry per cycle by a small sequencer
// around one compare unit. cmd_stall is high from acceptance until the
// result is loaded into the output register, so one command is worked on
// at a time; the next command may be accepted while the result waits.
// Actions with no sweep (full, empty, undefined) go straight to the
// response state; insert and the other actions sweep the tables, one
// entry per table read, so their work grows with the entry count.
// Neighbor queries add table reads for the successor and the top entry.
// Reset clears the entry count and all handshake state; the tables need no
// clearing since only entries below the count are read. While res_stall is
// high with a result held, that result holds and a finished command waits in its final state.
// ----------------------------------------------------------------------------
module sorted_key_ring_neighbors (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  skrn_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output skrn_pkg::res_t  res
);
	import skrn_pkg::*;

	// Sequencer state codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DOWN = 3'd1;
	localparam logic [2:0] S_PUT  = 3'd2;
	localparam logic [2:0] S_UP   = 3'd3;
	localparam logic [2:0] S_NRD  = 3'd4;
	localparam logic [2:0] S_NRW  = 3'd5;
	localparam logic [2:0] S_NLW  = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	// Entry tables
	logic [KEY_BITS-1:0] key_mem_q [CAPACITY];
	logic [HDL_W-1:0]    hdl_mem_q [CAPACITY];
	logic [KEY_BITS-1:0] key_rd_q;
	logic [HDL_W-1:0]    hdl_rd_q;

	// Control state
	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic             more_q, more_d;
	logic             pend_q, pend_d;
	logic             hit_q, hit_d;
	logic             res_vld_q;

	// Working payload
	logic [ACT_W-1:0]    act_q, act_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [HDL_W-1:0]    hdl_q, hdl_d;
	logic [IDX_W-1:0]    pidx_q, pidx_d;
	logic [IDX_W-1:0]    pos_q, pos_d;
	logic [KEY_BITS-1:0] prev_key_q, prev_key_d;
	logic [STAT_W-1:0]   st_q, st_d;
	logic [KEY_BITS-1:0] left_q, left_d;
	logic [KEY_BITS-1:0] right_q, right_d;
	logic [KEY_BITS-1:0] fkey_q, fkey_d;
	logic [HDL_W-1:0]    fhdl_q, fhdl_d;
	res_t                res_q;

	// Table port controls
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic                wr_key_en;
	logic                wr_hdl_en;
	logic [KEY_BITS-1:0] wr_key_d;
	logic [HDL_W-1:0]    wr_hdl_d;

	// Shared compare results
	logic match;
	logic last;
	logic pos_last;
	logic load_res;

	assign match    = (act_q == ACT_KEYOF) ? (hdl_rd_q == hdl_q) : (key_rd_q == key_q);
	assign last     = (CNT_W'(pidx_q) + CNT_W'(1)) == cnt_q;
	assign pos_last = (CNT_W'(pos_q) + CNT_W'(1)) == cnt_q;
	assign load_res = (state_q == S_RESP) && (!res_vld_q || !res_stall);

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_vld_q;
	assign res       = res_q;

	// Sequencer: sweep the tables one entry per cycle
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ptr_d      = ptr_q;
		more_d     = more_q;
		pend_d     = pend_q;
		hit_d      = hit_q;
		act_d      = act_q;
		key_d      = key_q;
		hdl_d      = hdl_q;
		pidx_d     = pidx_q;
		pos_d      = pos_q;
		prev_key_d = prev_key_q;
		st_d       = st_q;
		left_d     = left_q;
		right_d    = right_q;
		fkey_d     = fkey_q;
		fhdl_d     = fhdl_q;
		rd_addr    = ptr_q[IDX_W-1:0];
		wr_addr    = '0;
		wr_key_en  = 1'b0;
		wr_hdl_en  = 1'b0;
		wr_key_d   = key_rd_q;
		wr_hdl_d   = hdl_rd_q;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					act_d   = cmd.action;
					key_d   = cmd.key[KEY_BITS-1:0];
					hdl_d   = cmd.handle;
					st_d    = ST_OK;
					left_d  = '0;
					right_d = '0;
					fkey_d  = '0;
					fhdl_d  = NO_HANDLE;
					hit_d   = 1'b0;
					pend_d  = 1'b0;
					if (cmd.action == ACT_INSERT) begin
						if (cnt_q == CNT_W'(CAPACITY)) begin
							st_d    = ST_FULL;
							state_d = S_RESP;
						end else if (cnt_q == '0) begin
							state_d = S_PUT;
						end else begin
							ptr_d   = cnt_q - CNT_W'(1);
							more_d  = 1'b1;
							state_d = S_DOWN;
						end
					end else if (cmd.action > ACT_KEYOF) begin
						state_d = S_RESP;
					end else if (cnt_q == '0) begin
						st_d    = ST_EMPTY;
						state_d = S_RESP;
					end else begin
						ptr_d   = '0;
						more_d  = 1'b1;
						state_d = S_UP;
					end
				end
			end

			// Insert: walk down from the top, moving larger or equal keys up
			S_DOWN: begin
				if (more_q) begin
					pend_d = 1'b1;
					pidx_d = ptr_q[IDX_W-1:0];
					ptr_d  = ptr_q - CNT_W'(1);
					more_d = (ptr_q != '0);
				end else begin
					pend_d = 1'b0;
				end
				if (pend_q) begin
					wr_addr   = pidx_q + IDX_W'(1);
					wr_key_en = 1'b1;
					wr_hdl_en = 1'b1;
					if (key_rd_q >= key_q) begin
						if (pidx_q == '0) begin
							state_d = S_PUT;
						end
					end else begin
						wr_key_d = key_q;
						wr_hdl_d = NO_HANDLE;
						cnt_d    = cnt_q + CNT_W'(1);
						state_d  = S_RESP;
					end
				end
			end

			// Insert at the bottom of the table
			S_PUT: begin
				wr_addr   = '0;
				wr_key_en = 1'b1;
				wr_hdl_en = 1'b1;
				wr_key_d  = key_q;
				wr_hdl_d  = NO_HANDLE;
				cnt_d     = cnt_q + CNT_W'(1);
				state_d   = S_RESP;
			end

			// Lookup sweep upward; after a delete hit, shift entries down
			S_UP: begin
				if (more_q) begin
					pend_d = 1'b1;
					pidx_d = ptr_q[IDX_W-1:0];
					ptr_d  = ptr_q + CNT_W'(1);
					more_d = (ptr_q + CNT_W'(1)) < cnt_q;
				end else begin
					pend_d = 1'b0;
				end
				if (pend_q) begin
					prev_key_d = key_rd_q;
					if (hit_q) begin
						wr_addr   = pidx_q - IDX_W'(1);
						wr_key_en = 1'b1;
						wr_hdl_en = 1'b1;
						if (last) begin
							cnt_d   = cnt_q - CNT_W'(1);
							state_d = S_RESP;
						end
					end else if (match) begin
						pos_d = pidx_q;
						unique case (act_q)
							ACT_DELETE: begin
								hit_d = 1'b1;
								if (last) begin
									cnt_d   = cnt_q - CNT_W'(1);
									state_d = S_RESP;
								end
							end
							ACT_NEIGH: begin
								if (cnt_q == CNT_W'(1)) begin
									state_d = S_RESP;
								end else begin
									if (pidx_q != '0) begin
										left_d = prev_key_q;
									end
									state_d = S_NRD;
								end
							end
							ACT_SET: begin
								wr_addr   = pidx_q;
								wr_hdl_en = 1'b1;
								wr_hdl_d  = hdl_q;
								state_d   = S_RESP;
							end
							ACT_GET: begin
								fhdl_d  = hdl_rd_q;
								state_d = S_RESP;
							end
							ACT_KEYOF: begin
								fkey_d  = key_rd_q;
								state_d = S_RESP;
							end
							default: begin
								state_d = S_RESP;
							end
						endcase
					end else if (last) begin
						st_d    = ST_MISSING;
						state_d = S_RESP;
					end
				end
			end

			// Neighbors: fetch the successor, wrapping to the bottom
			S_NRD: begin
				rd_addr = pos_last ? '0 : (pos_q + IDX_W'(1));
				state_d = S_NRW;
			end

			// Take the successor; fetch the top entry when the hit was the bottom
			S_NRW: begin
				right_d = key_rd_q;
				rd_addr = IDX_W'(cnt_q - CNT_W'(1));
				state_d = (pos_q == '0) ? S_NLW : S_RESP;
			end

			S_NLW: begin
				left_d  = key_rd_q;
				state_d = S_RESP;
			end

			// Hold until the output register is free
			S_RESP: begin
				if (!res_vld_q || !res_stall) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Table write and registered read
	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem_q[wr_addr] <= wr_key_d;
		end
		if (wr_hdl_en) begin
			hdl_mem_q[wr_addr] <= wr_hdl_d;
		end
		key_rd_q <= key_mem_q[rd_addr];
		hdl_rd_q <= hdl_mem_q[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			more_q    <= 1'b0;
			pend_q    <= 1'b0;
			hit_q     <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			more_q  <= more_d;
			pend_q  <= pend_d;
			hit_q   <= hit_d;
			if (load_res) begin
				res_vld_q <= 1'b1;
			end else if (!res_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Working payload and result transaction
	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		act_q      <= act_d;
		key_q      <= key_d;
		hdl_q      <= hdl_d;
		pidx_q     <= pidx_d;
		pos_q      <= pos_d;
		prev_key_q <= prev_key_d;
		st_q       <= st_d;
		left_q     <= left_d;
		right_q    <= right_d;
		fkey_q     <= fkey_d;
		fhdl_q     <= fhdl_d;
		if (load_res) begin
			res_q.status       <= st_q;
			res_q.left_key     <= KEY_W'(left_q);
			res_q.right_key    <= KEY_W'(right_q);
			res_q.found_key    <= KEY_W'(fkey_q);
			res_q.found_handle <= fhdl_q;
			res_q.entry_total  <= TOTAL_W'(cnt_q);
		end
	end

`ifndef SYNTHESIS
	// Entry count stays within the table
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	// An accepted command always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q != S_IDLE))
		else $error("accepted command did not leave idle");

	// A result is only presented after the sequencer finished
	a_res_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> ($past(state_q) == S_RESP))
		else $error("result raised outside the response state");

	// The entry count only moves on the way to a response
	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (state_q == S_RESP))
		else $error("entry count changed mid-sweep");
`endif

endmodule
